// ----- src/pmsw_pkg.sv -----
// Package for the subset Prim spanning tree unit.
// Holds shared codes, the controller state type and the command/status structs.
`timescale 1ns / 1ps
package pmsw_pkg;

  localparam int unsigned TOTAL_W = 22;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_MEMBER = 2'd1,
    MODE_START  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROOT,
    ST_EMIT,
    ST_RELAX,
    ST_DRAIN,
    ST_DECIDE,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic load_w;
    logic load_m;
    logic init_clr;
    logic init_step;
    logic take_root;
    logic emit_node;
    logic relax_clr;
    logic relax_issue;
    logic take_best;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic cnt_last;
    logic root_found;
    logic best_found;
    logic out_free;
  } status_t;

endpackage

// ----- src/pmsw_ctrl.sv -----
// Controller state machine of the subset Prim spanning tree unit.
// Depends on pmsw_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps
module pmsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pmsw_pkg::mode_e   in_mode_i,
  input  pmsw_pkg::status_t status_i,
  output pmsw_pkg::cmd_t    cmd_o
);
  import pmsw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_WEIGHT: cmd_o.load_w = 1'b1;
            MODE_MEMBER: cmd_o.load_m = 1'b1;
            MODE_START: begin
              cmd_o.init_clr = 1'b1;
              state_d        = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        if (status_i.n_zero) begin
          state_d = ST_LAST;
        end else begin
          cmd_o.init_step = 1'b1;
          if (status_i.cnt_last) state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status_i.root_found) begin
          cmd_o.take_root = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_node = 1'b1;
          cmd_o.relax_clr = 1'b1;
          state_d         = ST_RELAX;
        end
      end
      ST_RELAX: begin
        cmd_o.relax_issue = 1'b1;
        if (status_i.cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (status_i.best_found) begin
          cmd_o.take_best = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/pmsw_dp.sv -----
// Datapath of the subset Prim spanning tree unit: weight, key, parent and
// pending memories, scan counter, minimum tracker and result register.
// Depends on pmsw_pkg.
`timescale 1ns / 1ps
module pmsw_dp #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned WEIGHT_BITS = 16,
  localparam int unsigned NW = $clog2(MAX_NODES),
  localparam int unsigned CW = $clog2(MAX_NODES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmsw_pkg::cmd_t               cmd_i,
  output pmsw_pkg::status_t            status_o,
  input  logic [NW-1:0]                row_i,
  input  logic [NW-1:0]                col_i,
  input  logic [WEIGHT_BITS-1:0]       weight_i,
  input  logic                         member_i,
  input  logic                         cfg_valid_i,
  input  logic [CW-1:0]                cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [NW-1:0]                out_parent_o,
  output logic [NW-1:0]                out_child_o,
  output logic [WEIGHT_BITS-1:0]       out_edge_o,
  output logic [pmsw_pkg::TOTAL_W-1:0] out_total_o,
  output logic                         out_last_o
);
  import pmsw_pkg::*;

  localparam int unsigned WB = WEIGHT_BITS;
  localparam int unsigned SW = ((WB > TOTAL_W) ? WB : TOTAL_W) + 1;
  localparam logic [WB-1:0] INF_CODE = '1;

  logic [WB-1:0] wmem [2**(2*NW)];
  logic [WB-1:0] key_mem [MAX_NODES];
  logic [NW-1:0] par_mem [MAX_NODES];
  logic          pend_mem [MAX_NODES];

  logic [MAX_NODES-1:0] member_q;
  logic [CW-1:0]        node_count_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        n_act;
  logic [NW-1:0]        cnt_idx;

  logic [WB-1:0] w_rd_q, key_rd_q;
  logic [NW-1:0] par_rd_q;
  logic          pend_rd_q;
  logic          d1_valid_q;
  logic [NW-1:0] v_d1_q;

  logic [NW-1:0]      u_q, upar_q, root_q, best_q, best_par_q;
  logic [WB-1:0]      ukey_q, best_key_q;
  logic               first_q, root_found_q, best_found_q;
  logic [TOTAL_W-1:0] total_q, total_sat;
  logic [SW-1:0]      sum;

  logic          out_valid_q, out_last_q;
  logic [NW-1:0] out_par_q, out_chi_q;
  logic [WB-1:0] out_ew_q;
  logic [TOTAL_W-1:0] out_tot_q;

  logic          pend_eff, upd, better;
  logic [WB-1:0] nkey;
  logic [NW-1:0] npar;
  logic          out_free;
  logic          cur_member;

  assign cnt_idx    = cnt_q[NW-1:0];
  assign n_act      = (node_count_q > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count_q;
  assign cur_member = member_q[cnt_idx];
  assign out_free   = !out_valid_q || out_ready_i;

  assign pend_eff = d1_valid_q && pend_rd_q && (v_d1_q != u_q);
  assign upd      = pend_eff && (w_rd_q < key_rd_q);
  assign nkey     = upd ? w_rd_q : key_rd_q;
  assign npar     = upd ? u_q : par_rd_q;
  assign better   = pend_eff && (!best_found_q || (nkey < best_key_q));

  assign sum       = SW'(total_q) + SW'(ukey_q);
  assign total_sat = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign status_o.n_zero     = (n_act == '0);
  assign status_o.cnt_last   = (CW'(cnt_q + 1'b1) == n_act);
  assign status_o.root_found = root_found_q;
  assign status_o.best_found = best_found_q;
  assign status_o.out_free   = out_free;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_w && (CW'(row_i) < CW'(MAX_NODES)) && (CW'(col_i) < CW'(MAX_NODES))) begin
      wmem[{row_i, col_i}] <= weight_i;
    end
    w_rd_q <= wmem[{u_q, cnt_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      pend_mem[cnt_idx] <= cur_member;
      par_mem[cnt_idx]  <= cnt_idx;
      key_mem[cnt_idx]  <= (cur_member && !root_found_q) ? '0 : INF_CODE;
    end else begin
      if (upd) begin
        key_mem[v_d1_q] <= nkey;
        par_mem[v_d1_q] <= npar;
      end
      if (d1_valid_q && (v_d1_q == u_q)) pend_mem[v_d1_q] <= 1'b0;
    end
    key_rd_q  <= key_mem[cnt_idx];
    par_rd_q  <= par_mem[cnt_idx];
    pend_rd_q <= pend_mem[cnt_idx];
    v_d1_q    <= cnt_idx;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q     <= '0;
      node_count_q <= CW'(MAX_NODES);
      cnt_q        <= '0;
      d1_valid_q   <= 1'b0;
      first_q      <= 1'b0;
      root_found_q <= 1'b0;
      best_found_q <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      if (cmd_i.load_m && (CW'(row_i) < CW'(MAX_NODES))) member_q[row_i] <= member_i;
      d1_valid_q <= cmd_i.relax_issue;
      if (cmd_i.init_clr) begin
        cnt_q        <= '0;
        total_q      <= '0;
        root_found_q <= 1'b0;
      end
      if (cmd_i.init_step) begin
        cnt_q <= CW'(cnt_q + 1'b1);
        if (cur_member) root_found_q <= 1'b1;
      end
      if (cmd_i.take_root) first_q <= 1'b1;
      if (cmd_i.relax_clr) begin
        cnt_q        <= '0;
        best_found_q <= 1'b0;
      end
      if (cmd_i.relax_issue) cnt_q <= CW'(cnt_q + 1'b1);
      if (better) best_found_q <= 1'b1;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.emit_node) begin
        total_q <= total_sat;
        first_q <= 1'b0;
        if (!first_q) out_valid_q <= 1'b1;
      end
      if (cmd_i.emit_last) out_valid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step && cur_member && !root_found_q) root_q <= cnt_idx;
    if (cmd_i.take_root) begin
      u_q    <= root_q;
      upar_q <= root_q;
      ukey_q <= '0;
    end
    if (cmd_i.take_best) begin
      u_q    <= best_q;
      upar_q <= best_par_q;
      ukey_q <= best_key_q;
    end
    if (better) begin
      best_q     <= v_d1_q;
      best_key_q <= nkey;
      best_par_q <= npar;
    end
    if (cmd_i.emit_node && !first_q) begin
      out_par_q  <= upar_q;
      out_chi_q  <= u_q;
      out_ew_q   <= ukey_q;
      out_tot_q  <= '0;
      out_last_q <= 1'b0;
    end
    if (cmd_i.emit_last) begin
      out_par_q  <= '0;
      out_chi_q  <= '0;
      out_ew_q   <= '0;
      out_tot_q  <= total_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_parent_o = out_par_q;
  assign out_child_o  = out_chi_q;
  assign out_edge_o   = out_ew_q;
  assign out_total_o  = out_tot_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- src/prim_mst_subset_weight_unit.sv -----
// Top level of the subset Prim spanning tree unit: stream and config ports,
// field packing, controller and datapath. Depends on pmsw_pkg, pmsw_ctrl, pmsw_dp.
//
// Load transactions (weight, member flag) are taken in the idle state, which
// the controller does not leave for them. A start transaction with n active
// nodes first runs an initialisation sweep over the n nodes, then one relax
// sweep for each attached node, then emits the total. The sweep rate is set by
// the single read port of the weight memory, which visits one matrix entry per
// cycle while the keys are relaxed and the next minimum is tracked in the same
// sweep. One result for each attached node after the root, then a final
// result with tlast set carrying the saturated total.
`timescale 1ns / 1ps
module prim_mst_subset_weight_unit #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned WEIGHT_BITS = 16,
  localparam int unsigned NW    = $clog2(MAX_NODES),
  localparam int unsigned CW    = $clog2(MAX_NODES + 1),
  localparam int unsigned IN_W  = ((2 * NW + WEIGHT_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * NW + WEIGHT_BITS + pmsw_pkg::TOTAL_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // row_node, col_node, weight, member
  input  logic [1:0]       s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // parent_node, child_node, edge_weight, total_weight
  output logic             m_axis_tlast,   // is_last
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CW-1:0]    cfg_data_i      // node_count
);
  import pmsw_pkg::*;

  cmd_t    cmd;
  status_t status;
  mode_e   mode;

  logic [NW-1:0]          row, col, par, chi;
  logic [WEIGHT_BITS-1:0] weight, edge_w;
  logic                   member;
  logic [TOTAL_W-1:0]     total;

  assign mode   = mode_e'(s_axis_tuser);
  assign row    = s_axis_tdata[NW-1:0];
  assign col    = s_axis_tdata[2*NW-1:NW];
  assign weight = s_axis_tdata[2*NW+WEIGHT_BITS-1:2*NW];
  assign member = s_axis_tdata[2*NW+WEIGHT_BITS];

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = OUT_W'({total, edge_w, chi, par});

  pmsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pmsw_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .row_i        (row),
    .col_i        (col),
    .weight_i     (weight),
    .member_i     (member),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_parent_o (par),
    .out_child_o  (chi),
    .out_edge_o   (edge_w),
    .out_total_o  (total),
    .out_last_o   (m_axis_tlast)
  );

endmodule
